// ===== hw/rtl/qcid_pkg.sv =====
package qcid_pkg;

	localparam int BYTE_W    = 8;
	localparam int VERDICT_W = 2;
	localparam int IDX_W     = 5;
	localparam int BACKEND_W = 16;
	localparam int POS_W     = 7;

	localparam logic [VERDICT_W-1:0] VERDICT_NO_ID = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_ID    = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_SHORT = 2'd2;

	localparam logic [POS_W-1:0] OFS_ETH_HI = 7'd12;
	localparam logic [POS_W-1:0] OFS_ETH_LO = 7'd13;
	localparam logic [POS_W-1:0] OFS_PROTO  = 7'd23;
	localparam logic [POS_W-1:0] OFS_FLAGS  = 7'd42;
	localparam logic [POS_W-1:0] OFS_LEN    = 7'd47;
	localparam logic [POS_W-1:0] OFS_ID     = 7'd48;
	localparam logic [POS_W-1:0] POS_MAX    = 7'd127;

	localparam logic [BYTE_W-1:0] FLAG_MASK     = 8'hC0;
	localparam logic [BYTE_W-1:0] ETH_IPV4_HI   = 8'h08;
	localparam logic [BYTE_W-1:0] ETH_IPV4_LO   = 8'h00;
	localparam logic [BYTE_W-1:0] PROTO_UDP     = 8'd17;
	localparam logic [BYTE_W:0]   MIN_FRAME     = 9'd14;

	localparam logic [BACKEND_W-1:0] BACKEND_RESET = 16'd1;

endpackage

// ===== hw/rtl/qcid_if.sv =====
interface qcid_frame_if;
	logic                         valid;
	logic                         ready;
	logic [qcid_pkg::BYTE_W-1:0]  frame_byte;
	logic                         frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface qcid_result_if;
	logic                            valid;
	logic                            ready;
	logic [qcid_pkg::VERDICT_W-1:0]  verdict;
	logic [qcid_pkg::BYTE_W-1:0]     id_byte;
	logic [qcid_pkg::IDX_W-1:0]      id_index;
	logic [qcid_pkg::IDX_W-1:0]      id_length;
	logic [qcid_pkg::BACKEND_W-1:0]  backend;
	logic                            result_last;

	modport source (output valid, output verdict, output id_byte, output id_index,
		output id_length, output backend, output result_last, input ready);
	modport sink   (input valid, input verdict, input id_byte, input id_index,
		input id_length, input backend, input result_last, output ready);
endinterface

// ===== hw/rtl/quic_connection_id_extractor.sv =====
// QUIC long-header destination connection ID extractor.
// frame: one Ethernet frame byte per word, frame_last on the final byte.
// result: one word per connection ID byte (verdict 1), or a single word with
//   verdict 0 (not QUIC / bad or truncated ID) or 2 (frame under 14 bytes).
//   result_last marks the final word of each frame.
// cfg_wr_en / cfg_wr_data: backend number, written while idle.
// Result path: last byte -> input register -> emitter job -> output register;
//   further ID words leave the output register one per cycle while ready.
// Throughput: one frame byte per cycle. Bytes are buffered in an input
//   register; the ID emitter drains one word a cycle. While a previous frame's
//   ID words are still draining, the input register holds a byte that ends a
//   frame or is at or past the ID offset, and frame.ready drops until the emitter
//   sends its final word; the held byte advances in that same cycle.
// Reset: all frame state clears, backend number returns to 1, no results pend.
// Receiver stall: result words hold in the output register; the emitter and,
//   through it, the frame input back up as described above.
module quic_connection_id_extractor #(
	parameter int MAX_ID_BYTES = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	qcid_frame_if.sink                      frame,
	qcid_result_if.source                   result,
	input  logic                            cfg_wr_en,
	input  logic [qcid_pkg::BACKEND_W-1:0]  cfg_wr_data
);
	import qcid_pkg::*;

	localparam int IW = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1;
	localparam int LW = $clog2(MAX_ID_BYTES + 1);
	localparam int CW = LW + 1;

	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  last_s1;
	logic                  adv_s1;

	logic [POS_W-1:0]      pos_q;
	logic                  hdr_ok_q;
	logic [BYTE_W-1:0]     eth_hi_q;
	logic [BYTE_W-1:0]     dlen_q;

	logic                  hdr_ok_nx;
	logic [BYTE_W-1:0]     eth_hi_nx;
	logic [BYTE_W-1:0]     dlen_nx;
	logic [POS_W-1:0]      store_ofs;
	logic                  store_wr;
	logic [BYTE_W:0]       total;
	logic [BYTE_W:0]       need;
	logic [VERDICT_W-1:0]  verdict_nx;

	logic [BYTE_W-1:0]     id_store_q [MAX_ID_BYTES];

	logic [BACKEND_W-1:0]  backend_q;

	logic                  busy_q;
	logic [VERDICT_W-1:0]  job_verdict_q;
	logic [LW-1:0]         job_len_q;
	logic [IW-1:0]         idx_q;
	logic                  emit;
	logic                  emit_last;

	logic                  out_valid_q;
	logic [VERDICT_W-1:0]  out_verdict_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic [IDX_W-1:0]      out_index_q;
	logic [IDX_W-1:0]      out_length_q;
	logic [BACKEND_W-1:0]  out_backend_q;
	logic                  out_last_q;

	assign adv_s1 = valid_s1 &&
		!(busy_q && !(emit && emit_last) && (last_s1 || pos_q >= OFS_ID));
	assign frame.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.frame_byte;
			last_s1 <= frame.frame_last;
		end
	end

	always_comb begin
		hdr_ok_nx = hdr_ok_q;
		eth_hi_nx = eth_hi_q;
		dlen_nx   = dlen_q;
		store_ofs = pos_q - OFS_ID;
		store_wr  = 1'b0;
		if (pos_q == OFS_ETH_HI) begin
			eth_hi_nx = byte_s1;
		end else if (pos_q == OFS_ETH_LO) begin
			if (eth_hi_q != ETH_IPV4_HI || byte_s1 != ETH_IPV4_LO) begin
				hdr_ok_nx = 1'b0;
			end
		end else if (pos_q == OFS_PROTO) begin
			if (byte_s1 != PROTO_UDP) begin
				hdr_ok_nx = 1'b0;
			end
		end else if (pos_q == OFS_FLAGS) begin
			if ((byte_s1 & FLAG_MASK) != FLAG_MASK) begin
				hdr_ok_nx = 1'b0;
			end
		end else if (pos_q == OFS_LEN) begin
			dlen_nx = byte_s1;
		end else if (pos_q >= OFS_ID && store_ofs < POS_W'(MAX_ID_BYTES)) begin
			store_wr = 1'b1;
		end

		total = {2'b00, pos_q} + 9'd1;
		need  = {2'b00, OFS_ID} + {1'b0, dlen_nx};
		if (total < MIN_FRAME) begin
			verdict_nx = VERDICT_SHORT;
		end else if (hdr_ok_nx && total > {2'b00, OFS_LEN} && dlen_nx != '0 &&
				{1'b0, dlen_nx} <= 9'(MAX_ID_BYTES) && total >= need) begin
			verdict_nx = VERDICT_ID;
		end else begin
			verdict_nx = VERDICT_NO_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr_ok_q <= 1'b1;
			eth_hi_q <= '0;
			dlen_q   <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q    <= '0;
				hdr_ok_q <= 1'b1;
				eth_hi_q <= '0;
				dlen_q   <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				hdr_ok_q <= hdr_ok_nx;
				eth_hi_q <= eth_hi_nx;
				dlen_q   <= dlen_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && store_wr) begin
			id_store_q[store_ofs[IW-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backend_q <= BACKEND_RESET;
		end else if (cfg_wr_en) begin
			backend_q <= cfg_wr_data;
		end
	end

	assign emit      = busy_q && (!out_valid_q || result.ready);
	assign emit_last = (job_verdict_q != VERDICT_ID) ||
		(CW'(idx_q) + CW'(1) == CW'(job_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			busy_q <= 1'b1;
		end else if (emit && emit_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			job_verdict_q <= verdict_nx;
			job_len_q     <= dlen_nx[LW-1:0];
			idx_q         <= '0;
		end else if (emit && !emit_last) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_verdict_q <= job_verdict_q;
			out_last_q    <= emit_last;
			if (job_verdict_q == VERDICT_ID) begin
				out_byte_q    <= id_store_q[idx_q];
				out_index_q   <= IDX_W'(idx_q);
				out_length_q  <= IDX_W'(job_len_q);
				out_backend_q <= backend_q;
			end else begin
				out_byte_q    <= '0;
				out_index_q   <= '0;
				out_length_q  <= '0;
				out_backend_q <= '0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.verdict     = out_verdict_q;
	assign result.id_byte     = out_byte_q;
	assign result.id_index    = out_index_q;
	assign result.id_length   = out_length_q;
	assign result.backend     = out_backend_q;
	assign result.result_last = out_last_q;

endmodule

// ===== tb/quic_connection_id_extractor_tb.sv =====
`timescale 1ns / 1ps

module quic_connection_id_extractor_tb;
	import qcid_pkg::*;

	localparam int ID_MAX       = 20;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [BYTE_W-1:0]    id_byte;
		logic [IDX_W-1:0]     id_index;
		logic [IDX_W-1:0]     id_length;
		logic [BACKEND_W-1:0] backend;
		logic                 result_last;
	} cid_word_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [BACKEND_W-1:0] cfg_wr_data;

	qcid_frame_if  frame_ch();
	qcid_result_if result_ch();

	quic_connection_id_extractor #(
		.MAX_ID_BYTES(ID_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// frame tracker state
	logic [BACKEND_W-1:0] backend_m;
	logic [POS_W-1:0]     pos_m;
	logic                 hdr_ok_m;
	logic [BYTE_W-1:0]    eth_hi_m;
	logic [BYTE_W-1:0]    decl_len_m;
	logic [BYTE_W-1:0]    id_mem_m [ID_MAX];

	cid_word_t pending_words[$];
	logic [BYTE_W-1:0] frame_buf[$];

	int errors;
	int burst_left;
	int frames_sent;
	int bytes_sent;
	int cfg_writes;
	int seen_id;
	int seen_no_id;
	int seen_short;
	int idle_cycles;
	bit hold_req;

	task automatic clear_frame_track();
		pos_m      = '0;
		hdr_ok_m   = 1'b1;
		eth_hi_m   = '0;
		decl_len_m = '0;
	endtask

	task automatic track_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [POS_W-1:0] p;
		int total;
		int n;
		int k;
		cid_word_t w;
		p = pos_m;
		if (p == OFS_ETH_HI) begin
			eth_hi_m = b;
		end else if (p == OFS_ETH_LO) begin
			if (eth_hi_m != ETH_IPV4_HI || b != ETH_IPV4_LO)
				hdr_ok_m = 1'b0;
		end else if (p == OFS_PROTO) begin
			if (b != PROTO_UDP)
				hdr_ok_m = 1'b0;
		end else if (p == OFS_FLAGS) begin
			if ((b & FLAG_MASK) != FLAG_MASK)
				hdr_ok_m = 1'b0;
		end else if (p == OFS_LEN) begin
			decl_len_m = b;
		end else if (p >= OFS_ID && int'(p) - int'(OFS_ID) < ID_MAX) begin
			id_mem_m[int'(p) - int'(OFS_ID)] = b;
		end
		if (p < POS_MAX)
			pos_m = p + 1'b1;
		if (last) begin
			total = int'(p) + 1;
			n = int'(decl_len_m);
			w = '0;
			if (total < int'(MIN_FRAME)) begin
				w.verdict = VERDICT_SHORT;
				w.result_last = 1'b1;
				pending_words.push_back(w);
			end else if (hdr_ok_m && total > int'(OFS_LEN) && n != 0 && n <= ID_MAX &&
					total >= int'(OFS_ID) + n) begin
				for (k = 0; k < n; k++) begin
					w.verdict     = VERDICT_ID;
					w.id_byte     = id_mem_m[k];
					w.id_index    = k[IDX_W-1:0];
					w.id_length   = n[IDX_W-1:0];
					w.backend     = backend_m;
					w.result_last = (k == n - 1);
					pending_words.push_back(w);
				end
			end else begin
				w.verdict = VERDICT_NO_ID;
				w.result_last = 1'b1;
				pending_words.push_back(w);
			end
			clear_frame_track();
		end
	endtask

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				frame_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 64);
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.frame_byte <= b;
		frame_ch.frame_last <= last;
		do @(posedge clk); while (!frame_ch.ready);
		burst_left--;
		bytes_sent++;
		track_frame_byte(b, last);
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++)
			send_word(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic build_quic(input int id_len, input int total);
		int i;
		logic [BYTE_W-1:0] b;
		frame_buf.delete();
		for (i = 0; i < total; i++) begin
			b = 8'($urandom);
			if (i == OFS_ETH_HI)
				b = ETH_IPV4_HI;
			else if (i == OFS_ETH_LO)
				b = ETH_IPV4_LO;
			else if (i == OFS_PROTO)
				b = PROTO_UDP;
			else if (i == OFS_FLAGS)
				b = b | FLAG_MASK;
			else if (i == OFS_LEN)
				b = id_len[BYTE_W-1:0];
			frame_buf.push_back(b);
		end
	endtask

	task automatic build_noise(input int total);
		int i;
		logic [BYTE_W-1:0] b;
		frame_buf.delete();
		for (i = 0; i < total; i++) begin
			b = 8'($urandom);
			frame_buf.push_back(b);
		end
	endtask

	task automatic wait_drained();
		frame_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_backend(input logic [BACKEND_W-1:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		backend_m = v;
		cfg_writes++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		cid_word_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: expected none, actual verdict %0d byte %0d",
					$time, result_ch.verdict, result_ch.id_byte);
			end else begin
				want = pending_words.pop_front();
				check_field("verdict", 32'(want.verdict), 32'(result_ch.verdict));
				check_field("id_byte", 32'(want.id_byte), 32'(result_ch.id_byte));
				check_field("id_index", 32'(want.id_index), 32'(result_ch.id_index));
				check_field("id_length", 32'(want.id_length), 32'(result_ch.id_length));
				check_field("backend", 32'(want.backend), 32'(result_ch.backend));
				check_field("result_last", 32'(want.result_last),
					32'(result_ch.result_last));
				if (want.verdict == VERDICT_ID)
					seen_id++;
				else if (want.verdict == VERDICT_SHORT)
					seen_short++;
				else
					seen_no_id++;
			end
		end
	end

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("** quic_connection_id_extractor: FAILED **");
			$finish;
		end
	end

	initial begin : rx_pace
		rx_mode_t mode;
		int phase_left;
		int tick;
		result_ch.ready = 1'b0;
		mode = RX_OPEN;
		phase_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (phase_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(10, 80);
			end
			phase_left--;
			tick++;
			case (mode)
				RX_OPEN:   result_ch.ready <= 1'b1;
				RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
				RX_EVERY4: result_ch.ready <= (tick % 4) != 3;
				default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic test_short_frames();
		build_noise(1);
		send_frame();
		build_noise(13);
		send_frame();
	endtask

	task automatic test_header_checks();
		build_quic(1, 49);
		case ($urandom_range(0, 3))
			0: frame_buf[OFS_ETH_HI] = ETH_IPV4_HI ^ 8'($urandom_range(1, 255));
			1: frame_buf[OFS_ETH_LO] = ETH_IPV4_LO ^ 8'($urandom_range(1, 255));
			2: frame_buf[OFS_PROTO] = PROTO_UDP ^ 8'($urandom_range(1, 255));
			default: frame_buf[OFS_FLAGS] = frame_buf[OFS_FLAGS] &
				(8'h3F | (8'h40 << $urandom_range(0, 1)));
		endcase
		send_frame();
	endtask

	task automatic test_length_limits();
		int len;
		int total;
		case ($urandom_range(0, 2))
			0: begin
				len = 0;
				total = 48;
			end
			1: begin
				len = int'($urandom_range(ID_MAX + 1, 255));
				total = 48;
			end
			default: begin
				len = int'($urandom_range(2, 6));
				total = int'($urandom_range(43, 47 + len));
			end
		endcase
		build_quic(len, total);
		send_frame();
	endtask

	task automatic test_long_frame();
		build_quic(3, 130);
		send_frame();
	endtask

	task automatic test_backpressure();
		int i;
		hold_req = 1'b1;
		build_quic(ID_MAX, 48 + ID_MAX);
		for (i = 48; i < 48 + ID_MAX; i++)
			frame_buf[i] = 8'hFF;
		send_frame();
		build_quic(1, 49);
		frame_buf[48] = 8'h00;
		send_frame();
		wait_drained();
	endtask

	initial begin
		arst_n              = 1'b0;
		frame_ch.valid      = 1'b0;
		frame_ch.frame_byte = '0;
		frame_ch.frame_last = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		hold_req            = 1'b0;
		errors              = 0;
		burst_left          = 0;
		idle_cycles         = 0;
		backend_m           = BACKEND_RESET;
		foreach (id_mem_m[i])
			id_mem_m[i] = '0;
		clear_frame_track();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_header_checks();
		test_length_limits();
		test_long_frame();
		set_backend(BACKEND_W'($urandom));
		test_backpressure();
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d frames, %0d bytes, %0d backend writes, one %0d-cycle receiver hold",
			frames_sent, bytes_sent, cfg_writes, HOLD_CYCLES);
		$display("result words checked: %0d with ID, %0d without ID, %0d short frame",
			seen_id, seen_no_id, seen_short);
		if (errors == 0) begin
			$display("** quic_connection_id_extractor: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** quic_connection_id_extractor: FAILED **");
		end
		$finish;
	end

endmodule
